### sv/lcas_pkg.sv
package lcas_pkg;

  // Field widths of the request and result words
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned ACC_W       = 40;
  localparam int unsigned LABEL_W     = 4;
  localparam int unsigned FEAT_W      = 6;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned BATCH_W     = 10;
  localparam int unsigned MAX_BATCH   = 1024;
  localparam int unsigned BATCH_RESET = 64;

  // Accumulator sum width: one guard bit above the wider operand
  localparam int unsigned SUM_W = ((2 * DATA_W > ACC_W) ? 2 * DATA_W : ACC_W) + 1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REQ_WEIGHT  = 2'd0,
    REQ_BIAS    = 2'd1,
    REQ_FEATURE = 2'd2
  } lcas_req_e;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [LABEL_W-1:0]        label_index;
    logic [FEAT_W-1:0]         feature_index;
    logic signed [DATA_W-1:0]  value;
    logic [LABEL_W-1:0]        true_label;
    logic                      last_feature;
  } lcas_req_t;

  typedef struct packed {
    logic [LABEL_W-1:0]        predicted_label;
    logic                      is_correct;
    logic [COUNT_W-1:0]        correct_count;
    logic                      batch_done;
    logic signed [ACC_W-1:0]   best_score;
  } lcas_res_t;

  // Request word travelling along the cell chain
  typedef struct packed {
    logic      valid;
    lcas_req_t req;
  } lcas_item_t;

  // Running argmax handed from cell to cell
  typedef struct packed {
    logic                      valid;
    logic [LABEL_W-1:0]        true_label;
    logic [LABEL_W-1:0]        best_label;
    logic signed [ACC_W-1:0]   best_score;
  } lcas_tok_t;

endpackage

### sv/lcas_cell.sv
module lcas_cell #(
  parameter int unsigned IDX      = 0,
  parameter int unsigned FEATURES = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcas_pkg::lcas_item_t item_i,
  input  lcas_pkg::lcas_tok_t  tok_i,
  output lcas_pkg::lcas_item_t item_o,
  output lcas_pkg::lcas_tok_t  tok_o
);
  import lcas_pkg::*;

  localparam int unsigned FIDX_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(ACC_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(ACC_MIN);

  // Weight row of this label
  logic signed [DATA_W-1:0] w_mem [FEATURES];
  logic signed [DATA_W-1:0] w_rd_q;

  logic [FIDX_W-1:0] fidx;
  logic              feat_ok;
  logic              mine0;
  logic              wr_w;

  lcas_req_t                s1_req_q, s2_req_q;
  logic                     s1_valid_q, s2_valid_q;
  logic                     s1_fok_q;
  logic signed [DATA_W-1:0] s1_val;
  logic signed [2*DATA_W-1:0] prod_d, prod_q;

  logic signed [DATA_W-1:0] bias_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d, base, bias_ext, tok_score;
  logic signed [SUM_W-1:0]  sum;
  logic                     started_q, started_d;
  logic                     feat2, mine2;
  lcas_tok_t                tok_d, tok_q;

  // Stage 0: address decode, weight write and registered read
  assign fidx    = item_i.req.feature_index[FIDX_W-1:0];
  assign feat_ok = {1'b0, item_i.req.feature_index} < (FEAT_W+1)'(FEATURES);
  assign mine0   = item_i.req.label_index == LABEL_W'(IDX);
  assign wr_w    = item_i.valid && (item_i.req.req_type == REQ_WEIGHT) && mine0 && feat_ok;

  always_ff @(posedge clk_i) begin
    if (wr_w) begin
      w_mem[fidx] <= item_i.req.value;
    end
    w_rd_q <= w_mem[fidx];
  end

  // Stage 1: multiply; out-of-range positions add nothing
  assign s1_val = $signed(s1_req_q.value);

  always_comb begin
    prod_d = '0;
    if (s1_valid_q && s1_fok_q && (s1_req_q.req_type == REQ_FEATURE)) begin
      prod_d = w_rd_q * s1_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= item_i.valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_req_q <= item_i.req;
    s1_fok_q <= feat_ok;
    s2_req_q <= s1_req_q;
    prod_q   <= prod_d;
  end

  // Stage 2: bias write, saturating accumulate, argmax step
  assign feat2    = s2_valid_q && (s2_req_q.req_type == REQ_FEATURE);
  assign mine2    = s2_req_q.label_index == LABEL_W'(IDX);
  assign bias_ext = {{(ACC_W-DATA_W-FRAC_W){bias_q[DATA_W-1]}}, bias_q, {FRAC_W{1'b0}}};
  assign base     = started_q ? acc_q : bias_ext;
  assign sum      = SUM_W'(base) + SUM_W'(prod_q);
  assign tok_score = $signed(tok_i.best_score);

  always_comb begin
    if (sum > SUM_MAX) begin
      acc_d = ACC_MAX;
    end else if (sum < SUM_MIN) begin
      acc_d = ACC_MIN;
    end else begin
      acc_d = sum[ACC_W-1:0];
    end
  end

  assign started_d = !s2_req_q.last_feature;

  always_comb begin
    tok_d            = tok_i;
    tok_d.valid      = feat2 && s2_req_q.last_feature;
    tok_d.true_label = s2_req_q.true_label;
    // strict compare keeps the lowest index on a tie
    if ((IDX == 0) || (acc_d > tok_score)) begin
      tok_d.best_label = LABEL_W'(IDX);
      tok_d.best_score = acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && (s2_req_q.req_type == REQ_BIAS) && mine2) begin
      bias_q <= s2_req_q.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      started_q <= 1'b0;
      tok_q     <= '0;
    end else begin
      if (feat2) begin
        acc_q     <= acc_d;
        started_q <= started_d;
      end
      tok_q <= tok_d;
    end
  end

  // Registered hop of the request word to the next cell
  assign item_o = '{valid: s1_valid_q, req: s1_req_q};
  assign tok_o  = tok_q;

endmodule

### sv/lcas_tail.sv
module lcas_tail #(
  parameter int unsigned LABELS = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lcas_pkg::COUNT_W-1:0]  cfg_wdata_i,
  input  logic                          credit_take_i,
  input  lcas_pkg::lcas_tok_t           tok_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output lcas_pkg::lcas_res_t           res_o,
  output logic                          full_o
);
  import lcas_pkg::*;

  // Enough room for every result that can be in the chain
  localparam int unsigned QD     = LABELS + 4;
  localparam int unsigned PTR_W  = $clog2(QD);
  localparam int unsigned CRED_W = $clog2(QD + 1);

  logic [COUNT_W-1:0] batch_q, batch_eff;
  logic [BATCH_W-1:0] sib_q;
  logic [COUNT_W-1:0] tally_q, count;
  logic [COUNT_W-1:0] sib_next;
  logic               is_ok, done;
  lcas_res_t          res_d;

  lcas_res_t          fifo_q [QD];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CRED_W-1:0]  cnt_q, cred_q;
  logic               push, pop;

  // Batch size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_q <= COUNT_W'(BATCH_RESET);
    end else if (cfg_we_i) begin
      batch_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (batch_q == '0) begin
      batch_eff = COUNT_W'(1);
    end else if (batch_q > COUNT_W'(MAX_BATCH)) begin
      batch_eff = COUNT_W'(MAX_BATCH);
    end else begin
      batch_eff = batch_q;
    end
  end

  // Score the sample that leaves the last cell
  assign is_ok    = tok_i.best_label == tok_i.true_label;
  assign count    = tally_q + COUNT_W'(is_ok);
  assign sib_next = {1'b0, sib_q} + COUNT_W'(1);
  assign done     = sib_next >= batch_eff;

  always_comb begin
    res_d.predicted_label = tok_i.best_label;
    res_d.is_correct      = is_ok;
    res_d.correct_count   = count;
    res_d.batch_done      = done;
    res_d.best_score      = tok_i.best_score;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sib_q   <= '0;
      tally_q <= '0;
    end else if (tok_i.valid) begin
      if (done) begin
        sib_q   <= '0;
        tally_q <= '0;
      end else begin
        sib_q   <= sib_next[BATCH_W-1:0];
        tally_q <= count;
      end
    end
  end

  // Result queue
  assign push = tok_i.valid;
  assign pop  = valid_o && !stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      cred_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QD - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QD - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      cnt_q  <= cnt_q + CRED_W'(push) - CRED_W'(pop);
      cred_q <= cred_q + CRED_W'(credit_take_i) - CRED_W'(pop);
    end
  end

  assign valid_o = cnt_q != '0;
  assign res_o   = fifo_q[rd_ptr_q];
  // a credit is held from acceptance until the result word leaves
  assign full_o  = cred_q == CRED_W'(QD);

endmodule

### sv/linear_classifier_argmax_scorer.sv
// A result word leaves the last cell's token register and is written into the result queue.
// Throughput: one word per cycle while stall_o is low; each label cell has its own
// multiply-accumulate; the request word hops one cell per cycle with the running argmax alongside.
// Up to LABELS+4 results may be outstanding before stall_o rises.
// Reset clears accumulators, batch counters and result queue; batch size returns to 64.
// Weight and bias stores hold no reset value and must be written before use.
module linear_classifier_argmax_scorer #(
  parameter int unsigned FEATURES = 4,
  parameter int unsigned LABELS   = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  lcas_pkg::lcas_req_t           req_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output lcas_pkg::lcas_res_t           res_o,
  input  logic                          cfg_we_i,
  input  logic [lcas_pkg::COUNT_W-1:0]  cfg_wdata_i
);
  import lcas_pkg::*;

  lcas_item_t item_w [LABELS];
  lcas_tok_t  tok_w  [LABELS+1];
  logic       accept;
  logic       full;

  assign accept    = valid_i && !full;
  assign stall_o   = full;
  assign item_w[0] = '{valid: accept, req: req_i};
  assign tok_w[0]  = '0;

  // Row of label cells
  for (genvar j = 0; j < LABELS; j++) begin : g_cell
    if (j < LABELS - 1) begin : g_mid
      lcas_cell #(.IDX(j), .FEATURES(FEATURES)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .item_i (item_w[j]),
        .tok_i  (tok_w[j]),
        .item_o (item_w[j+1]),
        .tok_o  (tok_w[j+1])
      );
    end else begin : g_end
      lcas_cell #(.IDX(j), .FEATURES(FEATURES)) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .item_i (item_w[j]),
        .tok_i  (tok_w[j]),
        .item_o (),
        .tok_o  (tok_w[j+1])
      );
    end
  end

  // Batch scoring and result queue
  lcas_tail #(.LABELS(LABELS)) u_tail (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .credit_take_i (accept && (req_i.req_type == REQ_FEATURE) && req_i.last_feature),
    .tok_i         (tok_w[LABELS]),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .res_o         (res_o),
    .full_o        (full)
  );

`ifndef SYNTHESIS
  a_label_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ({1'b0, res_o.predicted_label} < (LABEL_W+1)'(LABELS)))
    else $error("predicted label beyond label count");

  a_correct_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.is_correct) |-> (res_o.correct_count != '0))
    else $error("correct prediction not counted");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_o.correct_count <= COUNT_W'(MAX_BATCH)))
    else $error("correct count above batch limit");

  a_no_result_from_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !valid_o)
    else $error("result word right after reset");
`endif

endmodule

### tb/tb_linear_classifier_argmax_scorer.sv
module tb_linear_classifier_argmax_scorer;
  import lcas_pkg::*;

  localparam int unsigned FEATURES    = 4;
  localparam int unsigned LABELS      = 3;
  localparam int unsigned LATENCY     = LABELS + 3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_WORDS = 80;
  localparam int unsigned FINAL_BATCH = 200;

  // req_type 3 has no meaning and is dropped by the block
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               valid_i;
  logic               stall_o;
  lcas_req_t          req_i;
  logic               valid_o;
  logic               stall_i;
  lcas_res_t          res_o;
  logic               cfg_we_i;
  logic [COUNT_W-1:0] cfg_wdata_i;

  linear_classifier_argmax_scorer #(
    .FEATURES(FEATURES),
    .LABELS  (LABELS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid_i),
    .stall_o    (stall_o),
    .req_i      (req_i),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Scorer state as the testbench sees it
  logic signed [DATA_W-1:0] weight_tab [LABELS][FEATURES];
  logic signed [DATA_W-1:0] bias_tab   [LABELS];
  logic signed [ACC_W-1:0]  score_reg  [LABELS];
  int unsigned              batch_len;
  int unsigned              batch_pos;
  int unsigned              correct_tally;
  bit                       in_sample;

  lcas_res_t   due_results [$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("linear_classifier_argmax_scorer verification failed");
      $finish;
    end
  end

  function automatic logic signed [ACC_W-1:0] clamp_score(input longint x);
    if (x > longint'(ACC_MAX)) return ACC_MAX;
    if (x < longint'(ACC_MIN)) return ACC_MIN;
    return x[ACC_W-1:0];
  endfunction

  // Apply one accepted word to the scorer state; queue the score word it yields
  function automatic void advance_scorer(input lcas_req_t w);
    lcas_res_t   r;
    int unsigned best;
    int unsigned cap;
    longint      prod;
    case (w.req_type)
      REQ_WEIGHT: begin
        if (w.label_index < LABELS && w.feature_index < FEATURES)
          weight_tab[w.label_index][w.feature_index] = w.value;
      end
      REQ_BIAS: begin
        if (w.label_index < LABELS) bias_tab[w.label_index] = w.value;
      end
      REQ_FEATURE: begin
        // first word of a sample: accumulators start from the biases
        if (!in_sample) begin
          foreach (score_reg[j]) score_reg[j] = clamp_score(longint'(bias_tab[j]) <<< FRAC_W);
          in_sample = 1'b1;
        end
        // out-of-range positions add nothing
        if (w.feature_index < FEATURES) begin
          foreach (score_reg[j]) begin
            prod = longint'(weight_tab[j][w.feature_index]) * longint'($signed(w.value));
            score_reg[j] = clamp_score(longint'(score_reg[j]) + prod);
          end
        end
        if (w.last_feature) begin
          // argmax, lowest label wins a tie
          best = 0;
          for (int j = 1; j < LABELS; j++) if (score_reg[j] > score_reg[best]) best = j;
          r.predicted_label = LABEL_W'(best);
          r.is_correct      = (best == w.true_label);
          correct_tally    += r.is_correct;
          r.correct_count   = COUNT_W'(correct_tally);
          cap = (batch_len == 0) ? 1 : (batch_len > MAX_BATCH) ? MAX_BATCH : batch_len;
          r.batch_done = (batch_pos + 1 >= cap);
          if (r.batch_done) begin
            batch_pos     = 0;
            correct_tally = 0;
          end else begin
            batch_pos++;
          end
          in_sample    = 1'b0;
          r.best_score = score_reg[best];
          due_results.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Every field random; callers override what matters
  function automatic lcas_req_t rand_word();
    lcas_req_t w;
    w.req_type      = 2'($urandom_range(0, 3));
    w.label_index   = LABEL_W'($urandom);
    w.feature_index = FEAT_W'($urandom);
    w.value         = DATA_W'($urandom);
    w.true_label    = LABEL_W'($urandom);
    w.last_feature  = 1'($urandom);
    return w;
  endfunction

  // Offer one word, hold it until taken, then update the expectation
  task automatic send_word(input lcas_req_t w);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    valid_i <= 1'b1;
    req_i   <= w;
    do @(posedge clk_i); while (stall_o);
    advance_scorer(w);
    @(negedge clk_i);
  endtask

  // Sender holds off until every score word is back and the chain is empty
  task automatic drain_results();
    valid_i <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 8) @(negedge clk_i);
  endtask

  task automatic write_batch_size(input logic [COUNT_W-1:0] n);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    batch_len = n;
  endtask

  task automatic send_weight(input int l, input int f, input logic signed [DATA_W-1:0] v);
    lcas_req_t w;
    w = rand_word();
    w.req_type      = REQ_WEIGHT;
    w.label_index   = LABEL_W'(l);
    w.feature_index = FEAT_W'(f);
    w.value         = v;
    send_word(w);
  endtask

  task automatic send_bias(input int l, input logic signed [DATA_W-1:0] v);
    lcas_req_t w;
    w = rand_word();
    w.req_type    = REQ_BIAS;
    w.label_index = LABEL_W'(l);
    w.value       = v;
    send_word(w);
  endtask

  task automatic send_feature(input int f, input logic signed [DATA_W-1:0] v,
                              input bit last, input int truth);
    lcas_req_t w;
    w = rand_word();
    w.req_type      = REQ_FEATURE;
    w.feature_index = FEAT_W'(f);
    w.value         = v;
    w.last_feature  = last;
    w.true_label    = LABEL_W'(truth);
    send_word(w);
  endtask

  // Fill both tables, then try writes outside them and the unused request
  task automatic test_load_tables();
    logic signed [DATA_W-1:0] extreme_vals [4] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
    lcas_req_t w;
    for (int l = 0; l < LABELS; l++)
      for (int f = 0; f < FEATURES; f++) send_weight(l, f, extreme_vals[(l + f) % 4]);
    // equal top biases set up a tie
    send_bias(0, 16'sh7FFF);
    send_bias(1, 16'sh7FFF);
    send_bias(2, 16'sh8000);
    send_weight(LABELS, 0, 16'sh1234);
    send_weight(0, 63, 16'sh1234);
    send_weight(15, FEATURES, 16'sh1234);
    send_bias(15, 16'sh4321);
    w = rand_word();
    w.req_type     = REQ_UNUSED;
    w.last_feature = 1'b1;
    send_word(w);
  endtask

  task automatic test_edge_samples();
    // only an out-of-range position: score is the bias, tie goes to label 0
    send_feature(63, 16'sh7FFF, 1'b1, 0);
    // same position twice
    send_feature(1, 16'sh7FFF, 1'b0, 0);
    send_feature(1, 16'sh8000, 1'b0, 0);
    send_feature(3, 16'sh0100, 1'b1, 15);
    // single-word sample at the negative extreme
    send_feature(0, 16'sh8000, 1'b1, 2);
    // full sample in order
    for (int f = 0; f < FEATURES; f++) send_feature(f, rand_value(), f == FEATURES - 1, 1);
  endtask

  task automatic test_batch_limits();
    // size 0 behaves as 1: every sample closes a batch
    write_batch_size('0);
    send_feature(0, rand_value(), 1'b1, 0);
    send_feature(2, rand_value(), 1'b1, 1);
    write_batch_size(COUNT_W'(5));
    repeat (3) send_feature($urandom_range(0, FEATURES - 1), rand_value(), 1'b1, 0);
    // lowered below the samples already seen: next sample closes the batch
    write_batch_size(COUNT_W'(2));
    send_feature(1, rand_value(), 1'b1, 0);
    send_feature(3, rand_value(), 1'b1, 0);
  endtask

  // Long sample driving one accumulator to each rail, then back off the top one
  task automatic test_saturation();
    send_weight(0, 0, 16'sh8000);
    send_weight(1, 0, 16'sh7FFF);
    send_weight(2, 0, 16'sh4000);
    send_weight(0, 1, 16'sh7FFF);
    send_weight(1, 1, 16'sh0000);
    send_weight(2, 1, 16'sh0000);
    repeat (530) send_feature(0, 16'sh8000, 1'b0, 0);
    send_feature(1, 16'sh8000, 1'b0, 0);
    send_feature(1, 16'sh8000, 1'b0, 0);
    send_feature(1, 16'sh8000, 1'b1, 0);
  endtask

  task automatic test_random_traffic();
    int unsigned sizes [6] = '{3, 0, 7, 2047, 1, 0};
    int unsigned sent;
    int unsigned len;
    lcas_req_t   w;
    sizes[5] = $urandom_range(2, 40);
    foreach (sizes[p]) begin
      write_batch_size(COUNT_W'(sizes[p]));
      // some phases run with one side never idling
      tx_gaps = (p % 3) != 2;
      rx_gaps = (p % 3) != 1;
      sent = 0;
      while (sent < PHASE_WORDS) begin
        w = rand_word();
        case ($urandom_range(0, 15))
          0, 1: begin
            w.req_type = REQ_WEIGHT;
            if ($urandom_range(0, 3) != 0) begin
              w.label_index   = LABEL_W'($urandom_range(0, LABELS - 1));
              w.feature_index = FEAT_W'($urandom_range(0, FEATURES - 1));
            end
            w.value = rand_value();
            send_word(w);
            sent++;
          end
          2: begin
            w.req_type = REQ_BIAS;
            if ($urandom_range(0, 3) != 0) w.label_index = LABEL_W'($urandom_range(0, LABELS - 1));
            w.value = rand_value();
            send_word(w);
            sent++;
          end
          3: begin
            w.req_type = REQ_UNUSED;
            send_word(w);
          end
          4: begin
            // stray word: opens a sample or runs into the next one
            w.req_type     = REQ_FEATURE;
            w.last_feature = 1'b0;
            send_word(w);
            sent++;
          end
          default: begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
              w = rand_word();
              w.req_type = REQ_FEATURE;
              if (k < FEATURES && $urandom_range(0, 7) != 0) w.feature_index = FEAT_W'(k);
              w.value        = rand_value();
              w.last_feature = (k == len - 1);
              if ($urandom_range(0, 3) != 0) w.true_label = LABEL_W'($urandom_range(0, LABELS - 1));
              send_word(w);
              sent++;
            end
          end
        endcase
      end
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // Long batch, every sample correct, so the count climbs with no idling
  task automatic test_full_batch();
    for (int l = 0; l < LABELS; l++)
      for (int f = 0; f < FEATURES; f++) send_weight(l, f, 16'sh0000);
    send_bias(0, -16'sd5);
    send_bias(1, 16'sd100);
    send_bias(2, 16'sd100);
    // close whatever batch is open
    write_batch_size(COUNT_W'(1));
    send_feature(0, rand_value(), 1'b1, 1);
    write_batch_size(COUNT_W'(FINAL_BATCH));
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    repeat (FINAL_BATCH) send_feature($urandom_range(0, 63), rand_value(), 1'b1, 1);
  endtask

  // Receiver stall bursts
  initial begin
    stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_gaps && $urandom_range(0, 4) == 0) begin
        stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
        stall_i <= 1'b0;
      end
    end
  end

  task automatic note_mismatch(input string why, input lcas_res_t want, input lcas_res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("score word %s at cycle %0d: exp label=%0d ok=%0d count=%0d done=%0d score=%0d",
               why, cycle_count, want.predicted_label, want.is_correct, want.correct_count,
               want.batch_done, want.best_score,
               "  got label=%0d ok=%0d count=%0d done=%0d score=%0d",
               got.predicted_label, got.is_correct, got.correct_count, got.batch_done,
               got.best_score);
  endtask

  // Check each score word taken against the oldest expectation
  always @(posedge clk_i) begin
    lcas_res_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (due_results.size() == 0) begin
        want = '0;
        note_mismatch("unexpected", want, res_o);
      end else begin
        want = due_results.pop_front();
        if (res_o.predicted_label !== want.predicted_label ||
            res_o.is_correct      !== want.is_correct      ||
            res_o.correct_count   !== want.correct_count   ||
            res_o.batch_done      !== want.batch_done      ||
            res_o.best_score      !== want.best_score)
          note_mismatch("mismatch", want, res_o);
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    valid_i       = 1'b0;
    req_i         = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    batch_len     = BATCH_RESET;
    batch_pos     = 0;
    correct_tally = 0;
    in_sample     = 1'b0;
    foreach (score_reg[j]) score_reg[j] = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_load_tables();
    test_edge_samples();
    test_batch_limits();
    test_saturation();
    test_random_traffic();
    test_full_batch();

    drain_results();
    if (mismatches == 0) begin
      $display("linear_classifier_argmax_scorer verification clean");
    end else begin
      $display("linear_classifier_argmax_scorer verification failed");
    end
    $finish;
  end

endmodule
